// ----- design/kdhc_pkg.sv -----
// shared types, constants and the chord table lookup for the key debouncer
package kdhc_pkg;

   localparam int FIELD_BITS     = 4;
   localparam int FILTER_BITS    = 8;
   localparam int LIMIT_BITS     = 16;
   localparam int CODE_BITS      = 8;
   localparam int MAP_BITS       = 64;
   localparam int CHORD_BITS     = 4;
   localparam int REQ_BITS       = 2 * FIELD_BITS;
   localparam int RSP_BITS       = 2 * FIELD_BITS + CODE_BITS;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_ADDR_BITS  = 6;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_LSB        = 3;

   localparam int DEF_CHANNELS   = 4;
   localparam int DEF_COUNT_BITS = 16;

   localparam logic [FILTER_BITS-1:0] RST_FAST_FILTER   = 8'd2;
   localparam logic [LIMIT_BITS-1:0]  RST_HOLD_RELEASE  = 16'd2000;
   localparam logic [LIMIT_BITS-1:0]  RST_STUCK_LIMIT   = 16'd20000;
   localparam logic [FILTER_BITS-1:0] RST_SLOW_FILTER   = 8'd10;
   localparam logic [LIMIT_BITS-1:0]  RST_CHORD_TRIGGER = LIMIT_BITS'(150 * 13 / 5);
   localparam logic [MAP_BITS-1:0]    RST_MAP_LOW       = 64'h2112_0003_1102_0100;
   localparam logic [MAP_BITS-1:0]    RST_MAP_HIGH      = 64'h3121_0013_0000_1F04;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FAST_FILTER   = 3'd0,
      REG_HOLD_RELEASE  = 3'd1,
      REG_STUCK_LIMIT   = 3'd2,
      REG_SLOW_FILTER   = 3'd3,
      REG_CHORD_TRIGGER = 3'd4,
      REG_MAP_LOW       = 3'd5,
      REG_MAP_HIGH      = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [FILTER_BITS-1:0] fast_filter;
      logic [LIMIT_BITS-1:0]  hold_release;
      logic [LIMIT_BITS-1:0]  stuck_limit;
      logic [FILTER_BITS-1:0] slow_filter;
      logic [LIMIT_BITS-1:0]  chord_trigger;
      logic [MAP_BITS-1:0]    map_low;
      logic [MAP_BITS-1:0]    map_high;
   } cfg_type;

   typedef struct packed {
      logic key;
      logic stuck;
   } hit_status_type;

   function automatic logic [CODE_BITS-1:0] chord_lookup(
      input logic [MAP_BITS-1:0]   map_low,
      input logic [MAP_BITS-1:0]   map_high,
      input logic [CHORD_BITS-1:0] idx
   );
      logic [MAP_BITS-1:0] word;
      word = idx[CHORD_BITS-1] ? map_high : map_low;
      return word[{idx[CHORD_BITS-2:0], 3'b000} +: CODE_BITS];
   endfunction

endpackage

// ----- design/kdhc_hit_lane.sv -----
// one hit channel: rise and fall filter, hold release and stuck detection
module kdhc_hit_lane
   import kdhc_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   level,
   input  logic [FILTER_BITS-1:0] filter,
   input  logic [LIMIT_BITS-1:0]  hold_release,
   input  logic [LIMIT_BITS-1:0]  stuck_limit,
   output hit_status_type         status_next
);

   localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

   logic [FILTER_BITS-1:0] rise_ff, rise_in;
   logic [FILTER_BITS-1:0] fall_ff, fall_in;
   logic [COUNT_BITS-1:0]  hold_ff, hold_in;
   logic                   key_ff, key_in;
   logic                   stuck_ff, stuck_in;

   logic [CMP_BITS-1:0] hold_x;
   logic [CMP_BITS-1:0] hold_in_x;
   logic [CMP_BITS-1:0] release_x;
   logic [CMP_BITS-1:0] stuck_x;

   assign hold_x    = CMP_BITS'(hold_ff);
   assign hold_in_x = CMP_BITS'(hold_in);
   assign release_x = CMP_BITS'(hold_release);
   assign stuck_x   = CMP_BITS'(stuck_limit);

   always_comb begin
      rise_in  = rise_ff;
      fall_in  = fall_ff;
      hold_in  = hold_ff;
      key_in   = key_ff;
      stuck_in = stuck_ff;
      if (level) begin
         fall_in = '0;
         if (rise_ff < filter) begin
            rise_in = rise_ff + 1'b1;
         end
         if ((hold_x < stuck_x) && (hold_ff != '1)) begin
            hold_in = hold_ff + 1'b1;
         end
         if (rise_in >= filter) begin
            key_in = 1'b1;
         end
         if (hold_in_x >= release_x) begin
            key_in = 1'b0;
         end
         if (hold_in_x >= stuck_x) begin
            stuck_in = 1'b1;
         end
      end else begin
         rise_in = '0;
         if (fall_ff < filter) begin
            fall_in = fall_ff + 1'b1;
         end
         if (fall_in >= filter) begin
            key_in   = 1'b0;
            stuck_in = 1'b0;
            hold_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff  <= '0;
         fall_ff  <= '0;
         hold_ff  <= '0;
         key_ff   <= 1'b0;
         stuck_ff <= 1'b0;
      end else if (advance) begin
         rise_ff  <= rise_in;
         fall_ff  <= fall_in;
         hold_ff  <= hold_in;
         key_ff   <= key_in;
         stuck_ff <= stuck_in;
      end
   end

   assign status_next.key   = key_in;
   assign status_next.stuck = stuck_in;

endmodule

// ----- design/kdhc_button_lane.sv -----
// one button: rise and fall filter on the pressed level
module kdhc_button_lane
   import kdhc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   press,
   input  logic [FILTER_BITS-1:0] filter,
   output logic                   down_next
);

   logic [FILTER_BITS-1:0] rise_ff, rise_in;
   logic [FILTER_BITS-1:0] fall_ff, fall_in;
   logic                   down_ff, down_in;

   always_comb begin
      rise_in = rise_ff;
      fall_in = fall_ff;
      down_in = down_ff;
      if (press) begin
         fall_in = '0;
         if (rise_ff < filter) begin
            rise_in = rise_ff + 1'b1;
         end
         if (rise_in >= filter) begin
            down_in = 1'b1;
         end
      end else begin
         rise_in = '0;
         if (fall_ff < filter) begin
            fall_in = fall_ff + 1'b1;
         end
         if (fall_in >= filter) begin
            down_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff <= '0;
         fall_ff <= '0;
         down_ff <= 1'b0;
      end else if (advance) begin
         rise_ff <= rise_in;
         fall_ff <= fall_in;
         down_ff <= down_in;
      end
   end

   assign down_next = down_in;

endmodule

// ----- design/kdhc_chord_merge.sv -----
// merges the button lanes: chord hold counter, table lookup and code latch
module kdhc_chord_merge
   import kdhc_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [CHORD_BITS-1:0] chord,
   input  logic [LIMIT_BITS-1:0] trigger,
   input  logic [MAP_BITS-1:0]   map_low,
   input  logic [MAP_BITS-1:0]   map_high,
   output logic [CODE_BITS-1:0]  code_next
);

   localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [CODE_BITS-1:0]  latch_ff, latch_in;
   logic                  any_down;

   assign any_down = |chord;

   always_comb begin
      count_in = '0;
      if (any_down) begin
         count_in = (count_ff != '1) ? count_ff + 1'b1 : count_ff;
      end
      latch_in = latch_ff;
      if (latch_ff != '0) begin
         if (!any_down) begin
            latch_in = '0;
         end
      end else if (any_down && (CMP_BITS'(count_in) >= CMP_BITS'(trigger))) begin
         latch_in = chord_lookup(map_low, map_high, chord);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         latch_ff <= '0;
      end else if (advance) begin
         count_ff <= count_in;
         latch_ff <= latch_in;
      end
   end

   assign code_next = latch_in;

`ifndef SYNTHESIS
   a_latch_needs_count: assert property (@(posedge clock) disable iff (reset)
      (latch_ff != '0) |-> (count_ff != '0))
      else $error("chord code latched with hold counter at zero");
`endif

endmodule

// ----- design/key_debounce_hold_timeout_chord_core.sv -----
// top level: config registers, hit and button lanes, chord merge and output stage
// latency: a result beat is offered on rsp the cycle after its request beat is taken,
// or once the beat ahead of it has left when the output register is still occupied
// throughput: one beat per cycle while rsp_tready keeps up; a two-entry output stage keeps req_tready high
// while one result waits, so req_tready depends only on a registered flag
// reset: clears every filter, hold and chord counter, the latch and the output stage,
// and loads the register defaults; no clearing pass, beats are taken straight away
module key_debounce_hold_timeout_chord_core
   import kdhc_pkg::*;
#(
   parameter int CHANNELS   = DEF_CHANNELS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_BITS-1:0]      req_tdata,   // hit_levels[3:0], button_pins[7:4]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_BITS-1:0]      rsp_tdata,   // hit_keys[3:0], chord_code[11:4], stuck_flags[15:12]
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type                     cfg_ff;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic                        csr_write;

   logic                        req_accept;
   logic                        rsp_take;
   hit_status_type              hit_status [CHANNELS];
   logic [CHANNELS-1:0]         button_next;
   logic [FIELD_BITS-1:0]       keys_next;
   logic [FIELD_BITS-1:0]       stuck_next;
   logic [CHORD_BITS-1:0]       chord_next;
   logic [CODE_BITS-1:0]        code_next;
   logic [RSP_BITS-1:0]         result;

   logic                        rsp_valid_ff;
   logic [RSP_BITS-1:0]         rsp_data_ff;
   logic                        skid_valid_ff;
   logic [RSP_BITS-1:0]         skid_data_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_LSB +: CSR_INDEX_BITS];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_filter   <= RST_FAST_FILTER;
         cfg_ff.hold_release  <= RST_HOLD_RELEASE;
         cfg_ff.stuck_limit   <= RST_STUCK_LIMIT;
         cfg_ff.slow_filter   <= RST_SLOW_FILTER;
         cfg_ff.chord_trigger <= RST_CHORD_TRIGGER;
         cfg_ff.map_low       <= RST_MAP_LOW;
         cfg_ff.map_high      <= RST_MAP_HIGH;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FAST_FILTER:   cfg_ff.fast_filter   <= csr_pwdata[FILTER_BITS-1:0];
            REG_HOLD_RELEASE:  cfg_ff.hold_release  <= csr_pwdata[LIMIT_BITS-1:0];
            REG_STUCK_LIMIT:   cfg_ff.stuck_limit   <= csr_pwdata[LIMIT_BITS-1:0];
            REG_SLOW_FILTER:   cfg_ff.slow_filter   <= csr_pwdata[FILTER_BITS-1:0];
            REG_CHORD_TRIGGER: cfg_ff.chord_trigger <= csr_pwdata[LIMIT_BITS-1:0];
            REG_MAP_LOW:       cfg_ff.map_low       <= csr_pwdata[MAP_BITS-1:0];
            REG_MAP_HIGH:      cfg_ff.map_high      <= csr_pwdata[MAP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_FAST_FILTER:   csr_prdata = CSR_DATA_BITS'(cfg_ff.fast_filter);
         REG_HOLD_RELEASE:  csr_prdata = CSR_DATA_BITS'(cfg_ff.hold_release);
         REG_STUCK_LIMIT:   csr_prdata = CSR_DATA_BITS'(cfg_ff.stuck_limit);
         REG_SLOW_FILTER:   csr_prdata = CSR_DATA_BITS'(cfg_ff.slow_filter);
         REG_CHORD_TRIGGER: csr_prdata = CSR_DATA_BITS'(cfg_ff.chord_trigger);
         REG_MAP_LOW:       csr_prdata = CSR_DATA_BITS'(cfg_ff.map_low);
         REG_MAP_HIGH:      csr_prdata = CSR_DATA_BITS'(cfg_ff.map_high);
         default:           csr_prdata = '0;
      endcase
   end

   // lanes
   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_take   = rsp_valid_ff && rsp_tready;

   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      logic hit_level;
      logic button_press;
      if (i < FIELD_BITS) begin : g_pin
         assign hit_level    = req_tdata[i];
         assign button_press = ~req_tdata[FIELD_BITS + i];
      end else begin : g_none
         assign hit_level    = 1'b0;
         assign button_press = 1'b0;
      end

      kdhc_hit_lane #(
         .COUNT_BITS(COUNT_BITS)
      ) u_hit (
         .clock        (clock),
         .reset        (reset),
         .advance      (req_accept),
         .level        (hit_level),
         .filter       (cfg_ff.fast_filter),
         .hold_release (cfg_ff.hold_release),
         .stuck_limit  (cfg_ff.stuck_limit),
         .status_next  (hit_status[i])
      );

      kdhc_button_lane u_button (
         .clock     (clock),
         .reset     (reset),
         .advance   (req_accept),
         .press     (button_press),
         .filter    (cfg_ff.slow_filter),
         .down_next (button_next[i])
      );
   end

   for (genvar j = 0; j < FIELD_BITS; j++) begin : g_field
      if (j < CHANNELS) begin : g_used
         assign keys_next[j]  = hit_status[j].key;
         assign stuck_next[j] = hit_status[j].stuck;
         assign chord_next[j] = button_next[j];
      end else begin : g_unused
         assign keys_next[j]  = 1'b0;
         assign stuck_next[j] = 1'b0;
         assign chord_next[j] = 1'b0;
      end
   end

   kdhc_chord_merge #(
      .COUNT_BITS(COUNT_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .advance   (req_accept),
      .chord     (chord_next),
      .trigger   (cfg_ff.chord_trigger),
      .map_low   (cfg_ff.map_low),
      .map_high  (cfg_ff.map_high),
      .code_next (code_next)
   );

   assign result = {stuck_next, code_next, keys_next};

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (rsp_take) begin
            if (skid_valid_ff) begin
               rsp_data_ff   <= skid_data_ff;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= req_accept;
               if (req_accept) begin
                  rsp_data_ff <= result;
               end
            end
         end else if (req_accept) begin
            if (!rsp_valid_ff) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= result;
            end else begin
               skid_valid_ff <= 1'b1;
               skid_data_ff  <= result;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held with output register empty");

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no result beat");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_tready) |=> !skid_valid_ff)
      else $error("skid entry not drained after output taken");
`endif

endmodule

// ----- dv/key_debounce_hold_timeout_chord_checker.sv -----
// checker for the key debouncer: tracks register writes, predicts each result beat and compares
module key_debounce_hold_timeout_chord_checker
   import kdhc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_BITS-1:0]      req_tdata,   // hit_levels[3:0], button_pins[7:4]
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_BITS-1:0]      rsp_tdata,   // hit_keys[3:0], chord_code[11:4], stuck_flags[15:12]
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                     csr_pready,
   output int                       failures,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LANES = DEF_CHANNELS;
   localparam logic [LIMIT_BITS-1:0] COUNT_TOP = '1;

   typedef struct packed {
      logic [FIELD_BITS-1:0] stuck_flags;
      logic [CODE_BITS-1:0]  chord_code;
      logic [FIELD_BITS-1:0] hit_keys;
   } key_report_type;

   cfg_type                 cfg;
   logic [FILTER_BITS-1:0]  hit_rise [LANES];
   logic [FILTER_BITS-1:0]  hit_fall [LANES];
   logic [LIMIT_BITS-1:0]   hit_hold [LANES];
   logic [FILTER_BITS-1:0]  btn_rise [LANES];
   logic [FILTER_BITS-1:0]  btn_fall [LANES];
   logic [FIELD_BITS-1:0]   hit_on;
   logic [FIELD_BITS-1:0]   stuck_on;
   logic [FIELD_BITS-1:0]   btn_down;
   logic [LIMIT_BITS-1:0]   chord_held;
   logic [CODE_BITS-1:0]    chord_latched;
   key_report_type          pending_reports [$];
   int                      beat_no;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at result beat %0d: %s got 0x%0h, expected 0x%0h", beat_no, what, got,
               want);
      failures++;
   endtask

   function automatic key_report_type debounce_tick(input logic [FIELD_BITS-1:0] levels,
                                                     input logic [FIELD_BITS-1:0] pins);
      key_report_type      r;
      logic [MAP_BITS-1:0] word;
      for (int i = 0; i < LANES; i++) begin
         if (levels[i]) begin
            hit_fall[i] = '0;
            if (hit_rise[i] < cfg.fast_filter) hit_rise[i] = hit_rise[i] + 1'b1;
            if (hit_hold[i] < cfg.stuck_limit && hit_hold[i] < COUNT_TOP)
               hit_hold[i] = hit_hold[i] + 1'b1;
            if (hit_rise[i] >= cfg.fast_filter) hit_on[i] = 1'b1;
            if (hit_hold[i] >= cfg.hold_release) hit_on[i] = 1'b0;
            if (hit_hold[i] >= cfg.stuck_limit) stuck_on[i] = 1'b1;
         end else begin
            hit_rise[i] = '0;
            if (hit_fall[i] < cfg.fast_filter) hit_fall[i] = hit_fall[i] + 1'b1;
            if (hit_fall[i] >= cfg.fast_filter) begin
               hit_on[i]   = 1'b0;
               stuck_on[i] = 1'b0;
               hit_hold[i] = '0;
            end
         end
      end
      // buttons are active low
      for (int i = 0; i < LANES; i++) begin
         if (!pins[i]) begin
            btn_fall[i] = '0;
            if (btn_rise[i] < cfg.slow_filter) btn_rise[i] = btn_rise[i] + 1'b1;
            if (btn_rise[i] >= cfg.slow_filter) btn_down[i] = 1'b1;
         end else begin
            btn_rise[i] = '0;
            if (btn_fall[i] < cfg.slow_filter) btn_fall[i] = btn_fall[i] + 1'b1;
            if (btn_fall[i] >= cfg.slow_filter) btn_down[i] = 1'b0;
         end
      end
      if (btn_down != '0) begin
         if (chord_held < COUNT_TOP) chord_held = chord_held + 1'b1;
      end else begin
         chord_held = '0;
      end
      if (chord_latched != '0) begin
         if (btn_down == '0) chord_latched = '0;
      end else if (btn_down != '0 && chord_held >= cfg.chord_trigger) begin
         word = btn_down[FIELD_BITS-1] ? cfg.map_high : cfg.map_low;
         chord_latched = word[btn_down[FIELD_BITS-2:0] * CODE_BITS +: CODE_BITS];
      end
      r.hit_keys    = hit_on;
      r.chord_code  = chord_latched;
      r.stuck_flags = stuck_on;
      return r;
   endfunction

   always @(posedge clock) begin
      key_report_type seen;
      key_report_type want;
      if (reset) begin
         cfg = '{fast_filter: RST_FAST_FILTER, hold_release: RST_HOLD_RELEASE,
                 stuck_limit: RST_STUCK_LIMIT, slow_filter: RST_SLOW_FILTER,
                 chord_trigger: RST_CHORD_TRIGGER, map_low: RST_MAP_LOW,
                 map_high: RST_MAP_HIGH};
         for (int i = 0; i < LANES; i++) begin
            hit_rise[i] = '0;
            hit_fall[i] = '0;
            hit_hold[i] = '0;
            btn_rise[i] = '0;
            btn_fall[i] = '0;
         end
         hit_on        = '0;
         stuck_on      = '0;
         btn_down      = '0;
         chord_held    = '0;
         chord_latched = '0;
         pending_reports.delete();
         beat_no  = 0;
         failures = 0;
         pending  = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:CSR_LSB]))
               REG_FAST_FILTER:   cfg.fast_filter   = csr_pwdata[FILTER_BITS-1:0];
               REG_HOLD_RELEASE:  cfg.hold_release  = csr_pwdata[LIMIT_BITS-1:0];
               REG_STUCK_LIMIT:   cfg.stuck_limit   = csr_pwdata[LIMIT_BITS-1:0];
               REG_SLOW_FILTER:   cfg.slow_filter   = csr_pwdata[FILTER_BITS-1:0];
               REG_CHORD_TRIGGER: cfg.chord_trigger = csr_pwdata[LIMIT_BITS-1:0];
               REG_MAP_LOW:       cfg.map_low       = csr_pwdata;
               REG_MAP_HIGH:      cfg.map_high      = csr_pwdata;
               default: ;
            endcase
         end
         // a result leaves no earlier than the cycle after its request, so check before predicting
         if (rsp_tvalid && rsp_tready) begin
            seen = key_report_type'(rsp_tdata);
            if (pending_reports.size() == 0) begin
               report_mismatch("beat with nothing pending", int'(rsp_tdata), 0);
            end else begin
               want = pending_reports.pop_front();
               if (seen.hit_keys != want.hit_keys)
                  report_mismatch("hit_keys", seen.hit_keys, want.hit_keys);
               if (seen.chord_code != want.chord_code)
                  report_mismatch("chord_code", seen.chord_code, want.chord_code);
               if (seen.stuck_flags != want.stuck_flags)
                  report_mismatch("stuck_flags", seen.stuck_flags, want.stuck_flags);
            end
            beat_no++;
         end
         if (req_tvalid && req_tready)
            pending_reports.push_back(debounce_tick(req_tdata[FIELD_BITS-1:0],
                                                    req_tdata[REQ_BITS-1:FIELD_BITS]));
         pending = pending_reports.size();
      end
   end

endmodule

// ----- dv/key_debounce_hold_timeout_chord_core_tb.sv -----
// testbench top for the key debouncer: clock, reset, stimulus, idling and verdict
module key_debounce_hold_timeout_chord_core_tb
   import kdhc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_BITS-1:0] UNUSED_INDEX = 3'd7;
   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 120;
   localparam int HOLD_OFF     = 80;
   localparam int LONG_PRESS   = 300;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_BITS-1:0]      req_tdata   = '0;   // hit_levels[3:0], button_pins[7:4]
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_BITS-1:0]      rsp_tdata;          // hit_keys[3:0], chord_code[11:4], stuck_flags[15:12]
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int failures;
   int pending;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int run_cap           = 8;
   bit hold_off_pending  = 1'b0;

   key_debounce_hold_timeout_chord_core i_dut (.*);

   key_debounce_hold_timeout_chord_checker i_check (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .rsp_tvalid, .rsp_tready,
      .rsp_tdata, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .failures, .pending
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(index) << CSR_LSB;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // narrow registers get random upper bits, which must be dropped
   task automatic write_settings(input logic [FILTER_BITS-1:0] fast,
                                 input logic [LIMIT_BITS-1:0] hold,
                                 input logic [LIMIT_BITS-1:0] stuck,
                                 input logic [FILTER_BITS-1:0] slow,
                                 input logic [LIMIT_BITS-1:0] trigger,
                                 input logic [MAP_BITS-1:0] map_low,
                                 input logic [MAP_BITS-1:0] map_high);
      logic [CSR_DATA_BITS-1:0] pad;
      pad = {$urandom, $urandom};
      csr_write(REG_FAST_FILTER, {pad[CSR_DATA_BITS-1:FILTER_BITS], fast});
      csr_write(REG_HOLD_RELEASE, {pad[CSR_DATA_BITS-1:LIMIT_BITS], hold});
      csr_write(REG_STUCK_LIMIT, {pad[CSR_DATA_BITS-1:LIMIT_BITS], stuck});
      csr_write(REG_SLOW_FILTER, {pad[CSR_DATA_BITS-1:FILTER_BITS], slow});
      csr_write(REG_CHORD_TRIGGER, {pad[CSR_DATA_BITS-1:LIMIT_BITS], trigger});
      csr_write(REG_MAP_LOW, map_low);
      csr_write(REG_MAP_HIGH, map_high);
      run_cap = int'(fast) + int'(slow) + int'(trigger) + 6;
      if (run_cap > 150) run_cap = 150;
   endtask

   // chord table with some empty entries
   function automatic logic [MAP_BITS-1:0] random_map();
      logic [MAP_BITS-1:0] m;
      m = {$urandom, $urandom};
      for (int i = 0; i < MAP_BITS / CODE_BITS; i++)
         if ($urandom_range(0, 2) == 0) m[i * CODE_BITS +: CODE_BITS] = '0;
      return m;
   endfunction

   // entered and left at a falling edge
   task automatic send_tick(input logic [FIELD_BITS-1:0] levels,
                            input logic [FIELD_BITS-1:0] pins);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pins, levels};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // held levels and button chords with bounce, glitches and stray beats
   task automatic random_phase(input int count, input bit squeeze);
      int                    sent;
      int                    run;
      bit                    squeezed;
      logic [FIELD_BITS-1:0] levels;
      logic [FIELD_BITS-1:0] pins;
      levels   = 4'($urandom);
      pins     = '1;
      sent     = 0;
      squeezed = 1'b0;
      while (sent < count) begin
         if (squeeze && !squeezed && sent >= count / 2) begin
            hold_off_pending = 1'b1;
            squeezed = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_tick(4'($urandom), 4'($urandom));
            sent++;
         end else begin
            if ($urandom_range(0, 1) == 1) levels ^= 4'(1 << $urandom_range(0, 3));
            case ($urandom_range(0, 5))
               0:       pins = '1;
               1:       pins = 4'($urandom);
               2, 3:    pins ^= 4'(1 << $urandom_range(0, 3));
               default: ;
            endcase
            run = $urandom_range(1, run_cap);
            for (int k = 0; k < run && sent < count; k++) begin
               if ($urandom_range(0, 15) == 0)
                  send_tick(levels ^ 4'($urandom), pins ^ 4'($urandom));
               else
                  send_tick(levels, pins);
               sent++;
            end
         end
      end
   endtask

   initial begin
      logic [REQ_BITS-1:0] directed [20] = '{
         8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h5A, 8'hA5, 8'h11, 8'h22, 8'h44, 8'h88,
         8'hEE, 8'hDD, 8'hBB, 8'h77, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h0F, 8'h0F
      };
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero filters and zero stuck limit, then a write to an unused index
      sender_idle_pct   = 13;
      receiver_idle_pct = 62;
      write_settings(8'd0, 16'd2, 16'd0, 8'd0, 16'd1, random_map(), random_map());
      csr_write(UNUSED_INDEX, '1);
      foreach (directed[i]) send_tick(directed[i][FIELD_BITS-1:0],
                                      directed[i][REQ_BITS-1:FIELD_BITS]);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 3) begin
            sender_idle_pct   = 62;
            receiver_idle_pct = 13;
         end else if (phase == 6) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         case (phase)
            0: write_settings(RST_FAST_FILTER, RST_HOLD_RELEASE, RST_STUCK_LIMIT,
                              RST_SLOW_FILTER, RST_CHORD_TRIGGER, RST_MAP_LOW, RST_MAP_HIGH);
            1: write_settings(8'd1, 16'd1, 16'd1, 8'd1, 16'd1, '1, '0);
            2: write_settings(8'd2, 16'd70, 16'd25, 8'd3, 16'd12, random_map(), random_map());
            3: write_settings(8'd1, 16'd30, 16'd30, 8'd2, 16'd8, random_map(), random_map());
            default: write_settings(8'($urandom_range(0, 4)), 16'($urandom_range(0, 60)),
                                    16'($urandom_range(0, 90)), 8'($urandom_range(0, 6)),
                                    16'($urandom_range(0, 40)), random_map(), random_map());
         endcase
         random_phase(PHASE_ITEMS, phase == 1 || phase == 7);
         wait_drained();
      end

      // top of every range: filter counters run into saturation
      write_settings('1, '1, '1, '1, '1, random_map(), {8'hA5, 56'($urandom)});
      repeat (LONG_PRESS) send_tick(4'hF, 4'h0);
      repeat (300) send_tick(4'h0, 4'hF);
      wait_drained();
      repeat (5) @(negedge clock);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
